// ===== hw/rtl/ffpa_pkg.sv =====
package ffpa_pkg;

    localparam int SIZE_W  = 16;
    localparam int SUM_W   = 20;
    localparam int BIDX_W  = 4;
    localparam int BCNT_W  = 5;
    localparam int MODE_W  = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 80;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]        pad;
        logic              store_full;
        logic [SIZE_W-1:0] external_frag;
        logic [SUM_W-1:0]  free_total;
        logic [SUM_W-1:0]  internal_sum;
        logic [SIZE_W-1:0] leftover;
        logic [BIDX_W-1:0] chosen_block;
        logic              granted;
    } t_result;

endpackage

// ===== hw/rtl/ffpa_ram.sv =====
module ffpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/first_fit_partition_allocator.sv =====
// First-fit fixed-partition allocator.
// Input items arrive on the slave stream: tuser carries the mode (load, allocate,
// report), tdata the partition index and the size. Every item gives exactly one
// result item on the master stream. The partition count is set through the
// configuration write port; the user must write it only while the block is idle,
// which the block itself does not enforce. A load or an unused mode goes from
// idle straight to the finishing state. An allocate walks the partition sizes
// memory one entry per cycle, up to the first fit; the partitions examined are
// at most the partition count. A report walks the sizes memory and then the
// failed-request memory, up to the partitions and the failures stored.
// Each memory has a single read port, so both walks read one entry at a time.
// Only one item is in work at a time; o_s_tready is high while the sequencer is
// idle, and the next item is taken while a finished result still waits in the
// output register. If the receiver stalls, a finished result holds in its final
// state until the output register is free.
// Reset clears the used flags, the fragmentation sum, the failure count and the
// partition count; the memories hold only sizes and are not cleared, and the
// failed-request memory is read only at entries already written.
module first_fit_partition_allocator #(
    parameter int BLOCKS  = 16,
    parameter int PENDING = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [ffpa_pkg::IN_W-1:0]    i_s_tdata,   // block_index[3:0], size[19:4]
    input  logic [ffpa_pkg::MODE_W-1:0]  i_s_tuser,   // mode[1:0]
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // granted[0], chosen_block[4:1], leftover[20:5], internal_sum[40:21],
    // free_total[60:41], external_frag[76:61], store_full[77]
    output logic [ffpa_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                         i_cfg_we,
    input  logic [ffpa_pkg::BCNT_W-1:0]  i_cfg_wdata
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int PA_W  = (PENDING > 1) ? $clog2(PENDING) : 1;
    localparam int FC_W  = $clog2(PENDING + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_PEND  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                    r_state;
    logic [ffpa_pkg::BCNT_W-1:0]   r_block_count;
    logic [BLOCKS-1:0]             r_used;
    logic [ffpa_pkg::SUM_W-1:0]    r_frag;
    logic [FC_W-1:0]               r_fcount;
    logic [CNT_W-1:0]              r_scan;
    logic [FC_W-1:0]               r_fscan;
    logic [IDX_W-1:0]              r_chk_idx;
    logic                          r_chk_v;
    logic [ffpa_pkg::SIZE_W-1:0]   r_req;
    logic [ffpa_pkg::SUM_W-1:0]    r_tot;
    logic [ffpa_pkg::SIZE_W-1:0]   r_best;
    ffpa_pkg::t_result             r_res;
    ffpa_pkg::t_result             r_m_data;
    logic                          r_m_valid;

    logic [ffpa_pkg::SUM_W-1:0]    n_tot;
    logic [ffpa_pkg::SUM_W-1:0]    n_frag;
    logic [ffpa_pkg::SUM_W:0]      w_tot_sum;
    logic [ffpa_pkg::SUM_W:0]      w_frag_sum;
    logic [CNT_W-1:0]              w_n;
    logic                          w_in_acc;
    logic [ffpa_pkg::BIDX_W-1:0]   w_idx;
    logic [ffpa_pkg::SIZE_W-1:0]   w_size;
    logic                          w_idx_ok;
    logic                          w_blk_we;
    logic                          w_fail_we;
    logic                          w_hit;
    logic                          w_scan_more;
    logic                          w_room;
    logic [ffpa_pkg::SIZE_W-1:0]   w_blk_rdata;
    logic [ffpa_pkg::SIZE_W-1:0]   w_fail_rdata;
    logic                          w_out_load;
    ffpa_pkg::t_result             w_out;

    assign w_idx    = i_s_tdata[ffpa_pkg::BIDX_W-1:0];
    assign w_size   = i_s_tdata[ffpa_pkg::BIDX_W +: ffpa_pkg::SIZE_W];
    assign w_idx_ok = 32'(w_idx) < 32'(BLOCKS);
    assign w_in_acc = i_s_tvalid && o_s_tready;

    // A partition count beyond the storage acts as the full storage.
    always_comb begin
        if (32'(r_block_count) > 32'(BLOCKS)) begin
            w_n = CNT_W'(BLOCKS);
        end else begin
            w_n = CNT_W'(r_block_count);
        end
    end

    assign w_scan_more = r_scan < w_n;
    assign w_room      = 32'(r_fcount) < 32'(PENDING);
    assign w_hit       = r_chk_v && !r_used[r_chk_idx] && (w_blk_rdata >= r_req);

    // Memory writes happen only on acceptance or at the end of a walk, never in a
    // cycle where the same memory is being read for the current item.
    assign w_blk_we  = w_in_acc && (i_s_tuser == ffpa_pkg::MODE_LOAD) && w_idx_ok;
    assign w_fail_we = (r_state == S_ALLOC) && !r_chk_v && !w_scan_more && w_room;

    assign w_tot_sum  = {1'b0, r_tot} + (ffpa_pkg::SUM_W + 1)'(w_blk_rdata);
    assign w_frag_sum = {1'b0, r_frag} + (ffpa_pkg::SUM_W + 1)'(r_res.leftover);
    assign n_tot  = w_tot_sum[ffpa_pkg::SUM_W]  ? ffpa_pkg::SUM_MAX
                                                : w_tot_sum[ffpa_pkg::SUM_W-1:0];
    assign n_frag = w_frag_sum[ffpa_pkg::SUM_W] ? ffpa_pkg::SUM_MAX
                                                : w_frag_sum[ffpa_pkg::SUM_W-1:0];

    // The finished result moves to the output register once that register is free.
    assign w_out_load = (r_state == S_FIN) && (!r_m_valid || i_m_tready);

    always_comb begin
        w_out              = r_res;
        w_out.internal_sum = r_frag;
    end

    ffpa_ram #(
        .WIDTH (ffpa_pkg::SIZE_W),
        .DEPTH (BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (w_blk_we),
        .i_waddr (IDX_W'(w_idx)),
        .i_wdata (w_size),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (w_blk_rdata)
    );

    ffpa_ram #(
        .WIDTH (ffpa_pkg::SIZE_W),
        .DEPTH (PENDING)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_fail_we),
        .i_waddr (r_fcount[PA_W-1:0]),
        .i_wdata (r_req),
        .i_raddr (r_fscan[PA_W-1:0]),
        .o_rdata (w_fail_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= '0;
            r_used        <= '0;
            r_frag        <= '0;
            r_fcount      <= '0;
            r_chk_v       <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_res   <= '0;
                        r_req   <= w_size;
                        r_scan  <= '0;
                        r_fscan <= '0;
                        r_chk_v <= 1'b0;
                        r_tot   <= '0;
                        r_best  <= '0;
                        unique case (i_s_tuser)
                            ffpa_pkg::MODE_LOAD: begin
                                if (w_idx_ok) begin
                                    r_used[IDX_W'(w_idx)] <= 1'b0;
                                end
                                r_state <= S_FIN;
                            end
                            ffpa_pkg::MODE_ALLOC:  r_state <= S_ALLOC;
                            ffpa_pkg::MODE_REPORT: r_state <= S_FREE;
                            default:               r_state <= S_FIN;
                        endcase
                    end
                end
                S_ALLOC: begin
                    // One read is issued per cycle; the entry read in the previous
                    // cycle is checked against the request.
                    if (w_hit) begin
                        r_used[r_chk_idx]   <= 1'b1;
                        r_res.granted       <= 1'b1;
                        r_res.chosen_block  <= ffpa_pkg::BIDX_W'(r_chk_idx);
                        r_res.leftover      <= w_blk_rdata - r_req;
                        r_state             <= S_ACC;
                    end else if (w_scan_more) begin
                        r_chk_idx <= r_scan[IDX_W-1:0];
                        r_chk_v   <= 1'b1;
                        r_scan    <= r_scan + 1'b1;
                    end else if (r_chk_v) begin
                        r_chk_v <= 1'b0;
                    end else begin
                        if (w_room) begin
                            r_fcount <= r_fcount + 1'b1;
                        end else begin
                            r_res.store_full <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FREE: begin
                    if (r_chk_v && !r_used[r_chk_idx]) begin
                        r_tot <= n_tot;
                    end
                    if (w_scan_more) begin
                        r_chk_idx <= r_scan[IDX_W-1:0];
                        r_chk_v   <= 1'b1;
                        r_scan    <= r_scan + 1'b1;
                    end else if (r_chk_v) begin
                        r_chk_v <= 1'b0;
                    end else begin
                        r_state <= S_PEND;
                    end
                end
                S_PEND: begin
                    if (r_chk_v && (ffpa_pkg::SUM_W'(w_fail_rdata) <= r_tot)
                            && (w_fail_rdata > r_best)) begin
                        r_best <= w_fail_rdata;
                    end
                    if (r_fscan < r_fcount) begin
                        r_chk_v <= 1'b1;
                        r_fscan <= r_fscan + 1'b1;
                    end else if (r_chk_v) begin
                        r_chk_v <= 1'b0;
                    end else begin
                        r_res.free_total    <= r_tot;
                        r_res.external_frag <= r_best;
                        r_state             <= S_FIN;
                    end
                end
                S_ACC: begin
                    r_frag  <= n_frag;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_m_data <= w_out;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_m_valid && !i_m_tready) |=>
            (r_state == S_FIN && o_m_tvalid))
        else $error("finished result did not wait for the output register");

    a_fcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fcount) <= 32'(PENDING))
        else $error("failure count beyond the store depth");

    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(r_m_data.granted && r_m_data.store_full))
        else $error("result both granted and dropped");

    a_frag_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_frag >= $past(r_frag)))
        else $error("fragmentation sum decreased");

endmodule
